/* rtl/sha_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Round constants, initial hash values and the block item passed from the
// byte packer to the compression engine.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned BlkQDepth = 2;

  typedef struct packed {
    logic [15:0][31:0] words;     // words[0] is the first word of the block
    logic              final_blk; // last block of the message
    logic              dbl;       // hash the digest a second time
  } blk_t;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] res;
    unique case (idx)
      3'd0: res = 32'h6a09e667;
      3'd1: res = 32'hbb67ae85;
      3'd2: res = 32'h3c6ef372;
      3'd3: res = 32'ha54ff53a;
      3'd4: res = 32'h510e527f;
      3'd5: res = 32'h9b05688c;
      3'd6: res = 32'h1f83d9ab;
      default: res = 32'h5be0cd19;
    endcase
    return res;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[r];
  endfunction

endpackage

/* rtl/sha_front.sv */
// ----------------------------------------------------------------------------
// SHA-256 byte packer
// Packs message bytes into 512-bit blocks and appends the padding.
// ----------------------------------------------------------------------------
module sha_front import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        last_byte_i,
  input  logic        dbl_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output blk_t        q_data_o
);

  typedef enum logic [1:0] {F_IDLE, F_FILL, F_PUSH} fstate_e;

  fstate_e           st_q, st_d;
  logic [15:0][31:0] buf_q, buf_d;
  logic [60:0]       cnt_q, cnt_d, cnt_inc;
  logic [3:0]        wi_q, wi_d;
  logic              blk2_q, blk2_d;
  logic [63:0]       len_q, len_d;
  logic              dbl_q, dbl_d;
  logic              accept, fits, first_w, push_fin;
  logic [1:0]        lane;
  logic [31:0]       pad_w;

  assign full    = (st_q != F_IDLE) | q_full_i;
  assign accept  = push & ~full;
  assign cnt_inc = cnt_q + 61'd1;
  assign lane    = cnt_q[1:0];
  // The length fits in the current block unless fewer than nine bytes remain.
  assign fits    = blk2_q | (cnt_q[5:0] < 6'd56);
  assign first_w = ~blk2_q & (wi_q == cnt_q[5:2]);

  always_comb begin
    pad_w = 32'd0;
    if (first_w) begin
      pad_w = (buf_q[wi_q] & ~(32'hffffffff >> {lane, 3'b000}))
            | (32'h80000000 >> {lane, 3'b000});
    end else if (fits && wi_q == 4'd14) begin
      pad_w = len_q[63:32];
    end else if (fits && wi_q == 4'd15) begin
      pad_w = len_q[31:0];
    end
  end

  always_comb begin
    st_d     = st_q;
    buf_d    = buf_q;
    cnt_d    = cnt_q;
    wi_d     = wi_q;
    blk2_d   = blk2_q;
    len_d    = len_q;
    dbl_d    = dbl_q;
    q_push_o = 1'b0;
    push_fin = 1'b0;
    unique case (st_q)
      F_IDLE: begin
        if (accept) begin
          if (byte_present_i) begin
            buf_d[cnt_q[5:2]][(6'd31 - {1'b0, lane, 3'b000}) -: 8] = data_byte_i;
            cnt_d = cnt_inc;
            if (cnt_q[5:0] == 6'd63) begin
              q_push_o = 1'b1;
            end
          end
          if (last_byte_i) begin
            st_d   = F_FILL;
            blk2_d = 1'b0;
            wi_d   = cnt_d[5:2];
            len_d  = {cnt_d, 3'b000};
            dbl_d  = dbl_i;
          end
        end
      end
      F_FILL: begin
        buf_d[wi_q] = pad_w;
        if (wi_q == 4'd15) begin
          st_d = F_PUSH;
        end else begin
          wi_d = wi_q + 4'd1;
        end
      end
      default: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          push_fin = fits;
          if (fits) begin
            st_d  = F_IDLE;
            cnt_d = '0;
          end else begin
            blk2_d = 1'b1;
            wi_d   = 4'd0;
            st_d   = F_FILL;
          end
        end
      end
    endcase
  end

  assign q_data_o = '{words: buf_d, final_blk: push_fin, dbl: dbl_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= F_IDLE;
      cnt_q  <= '0;
      wi_q   <= '0;
      blk2_q <= 1'b0;
      dbl_q  <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      wi_q   <= wi_d;
      blk2_q <= blk2_d;
      dbl_q  <= dbl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    len_q <= len_d;
  end

endmodule

/* rtl/sha_blkq.sv */
// ----------------------------------------------------------------------------
// SHA-256 block queue
// A short register queue of whole blocks between packer and engine.
// ----------------------------------------------------------------------------
module sha_blkq import sha_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  blk_t data_i,
  output logic full_o,
  input  logic pop_i,
  output blk_t data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = $clog2(BlkQDepth);

  blk_t           mem_q [BlkQDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(BlkQDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(BlkQDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(BlkQDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* rtl/sha_core.sv */
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// One round per cycle, chaining state, second pass and digest buffer.
// ----------------------------------------------------------------------------
module sha_core import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  blk_t        q_data_i,
  output logic        q_pop_o,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  typedef enum logic [1:0] {C_IDLE, C_RND, C_ADD} cstate_e;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  cstate_e     st_q, st_d;
  logic [31:0] chain_q [8];
  logic [31:0] chain_d [8];
  logic [31:0] v_q [8];
  logic [31:0] v_d [8];
  logic [31:0] win_q [16];
  logic [31:0] win_d [16];
  logic [31:0] obuf_q [8];
  logic [31:0] obuf_d [8];
  logic [31:0] sum [8];
  logic [5:0]  r_q, r_d;
  logic        fin_q, fin_d, dbl_q, dbl_d, sec_q, sec_d, ov_q, ov_d;
  logic [2:0]  rd_q, rd_d;
  logic [31:0] t1, t2, w_new;

  assign t1 = v_q[7] + (ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25))
            + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(r_q) + win_q[0];
  assign t2 = (ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22))
            + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  assign w_new = (ror(win_q[14], 17) ^ ror(win_q[14], 19) ^ (win_q[14] >> 10))
               + win_q[9] + (ror(win_q[1], 7) ^ ror(win_q[1], 18) ^ (win_q[1] >> 3))
               + win_q[0];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sum[i] = chain_q[i] + v_q[i];
    end
  end

  always_comb begin
    st_d    = st_q;
    chain_d = chain_q;
    v_d     = v_q;
    win_d   = win_q;
    obuf_d  = obuf_q;
    r_d     = r_q;
    fin_d   = fin_q;
    dbl_d   = dbl_q;
    sec_d   = sec_q;
    ov_d    = ov_q;
    rd_d    = rd_q;
    q_pop_o = 1'b0;
    if (pop && ov_q) begin
      rd_d = rd_q + 3'd1;
      if (rd_q == 3'd7) begin
        ov_d = 1'b0;
      end
    end
    unique case (st_q)
      C_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          v_d     = chain_q;
          for (int i = 0; i < 16; i++) begin
            win_d[i] = q_data_i.words[i];
          end
          r_d   = '0;
          fin_d = q_data_i.final_blk;
          dbl_d = q_data_i.dbl;
          st_d  = C_RND;
        end
      end
      C_RND: begin
        for (int i = 0; i < 15; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[15] = w_new;
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        r_d    = r_q + 6'd1;
        if (r_q == 6'd63) begin
          st_d = C_ADD;
        end
      end
      default: begin
        if (!fin_q) begin
          chain_d = sum;
          st_d    = C_IDLE;
        end else if (dbl_q && !sec_q) begin
          // Second pass: the 32-byte digest is one padded block of its own.
          sec_d = 1'b1;
          for (int i = 0; i < 8; i++) begin
            chain_d[i] = iv_word(3'(i));
            v_d[i]     = iv_word(3'(i));
            win_d[i]   = sum[i];
          end
          win_d[8] = 32'h80000000;
          for (int i = 9; i < 15; i++) begin
            win_d[i] = 32'd0;
          end
          win_d[15] = 32'd256;
          r_d  = '0;
          st_d = C_RND;
        end else if (!ov_q) begin
          obuf_d = sum;
          ov_d   = 1'b1;
          rd_d   = '0;
          sec_d  = 1'b0;
          for (int i = 0; i < 8; i++) begin
            chain_d[i] = iv_word(3'(i));
          end
          st_d = C_IDLE;
        end
      end
    endcase
  end

  assign empty         = ~ov_q;
  assign digest_word_o = obuf_q[rd_q];
  assign word_index_o  = rd_q;
  assign last_word_o   = (rd_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= C_IDLE;
      r_q   <= '0;
      fin_q <= 1'b0;
      dbl_q <= 1'b0;
      sec_q <= 1'b0;
      ov_q  <= 1'b0;
      rd_q  <= '0;
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= iv_word(3'(i));
      end
    end else begin
      st_q    <= st_d;
      r_q     <= r_d;
      fin_q   <= fin_d;
      dbl_q   <= dbl_d;
      sec_q   <= sec_d;
      ov_q    <= ov_d;
      rd_q    <= rd_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    win_q  <= win_d;
    obuf_q <= obuf_d;
  end

endmodule

/* rtl/sha256_stream_hasher.sv */
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-wide message in, eight 32-bit digest words out per message.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   -------   ------------------   ------------------------------------------
//   input     push / full          data_byte_i, byte_present_i, last_byte_i
//   result    pop / empty          digest_word_o, word_index_o, last_word_o
//   config    double_mode_we_i     double_mode_i
//
// A byte is taken when push is high and full is low; every 64th byte hands a
// block to the engine, which loads it, runs 64 rounds and adds the result to
// the chaining state. The packer keeps taking bytes while the engine works,
// so sustained input is set by the round loop. A last item adds one or two
// padded blocks from the packer, and double mode a second engine pass.
// Reset clears all control state and loads the initial hash values.
// The packer stalls (full high) while padding or while the two-block queue is
// full; the engine stalls a final block while the previous digest is unread.
//
module sha256_stream_hasher import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        last_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o,
  input  logic        double_mode_we_i,
  input  logic        double_mode_i
);

  logic dbl_q;
  logic q_push, q_pop, q_full, q_empty;
  blk_t q_wdata, q_rdata;

  // Double-hash mode register; the packer samples it on the last item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbl_q <= 1'b0;
    end else if (double_mode_we_i) begin
      dbl_q <= double_mode_i;
    end
  end

  sha_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .last_byte_i    (last_byte_i),
    .dbl_i          (dbl_q),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_data_o       (q_wdata)
  );

  sha_blkq u_blkq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  sha_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

`ifndef NO_ASSERTIONS
  // The packer never hands a block to a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("block queue overflow");

  // The engine only takes a block that is there.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("block queue underflow");

  // Taking the final digest word drains the result buffer.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && last_word_o) |=> empty) else $error("digest not drained");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Streams messages in one byte per item and checks every digest word against
// a local SHA-256 predictor, in single and double hashing mode. A short table
// of directed items comes first, then random messages around block edges.
// ----------------------------------------------------------------------------
module tb_top;
  import sha_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 300;
  localparam int EdgeLen = 56;

  // Block ports.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte_i = '0;
  logic        byte_present_i = 1'b0;
  logic        last_byte_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;
  logic        double_mode_we_i = 1'b0;
  logic        double_mode_i = 1'b0;

  sha256_stream_hasher dut (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .data_byte_i,
    .byte_present_i,
    .last_byte_i,
    .empty,
    .pop,
    .digest_word_o,
    .word_index_o,
    .last_word_o,
    .double_mode_we_i,
    .double_mode_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // One expected digest word.
  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        lastw;
  } digest_word_t;

  digest_word_t digest_q[$];

  // Predictor state: chaining words, the current block, the byte count and
  // the double hashing mode as last written.
  logic [31:0] chain_hv[8];
  logic [7:0]  blk_bytes[64];
  logic [60:0] byte_count;
  logic        dbl_sel;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned words_seen = 0;
  bit          rst_done = 1'b0;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] iv_of(input int i);
    logic [31:0] iv[8];
    iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
           32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return iv[i];
  endfunction

  task automatic reload_iv();
    for (int i = 0; i < 8; i++) chain_hv[i] = iv_of(i);
  endtask

  // One 64-round compression of blk_bytes into chain_hv.
  task automatic compress_blk();
    logic [31:0] v[8];
    logic [31:0] w[16];
    logic [31:0] wn, t1, t2, x2, x15;
    for (int i = 0; i < 8; i++) v[i] = chain_hv[i];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wn = {blk_bytes[r*4], blk_bytes[r*4+1], blk_bytes[r*4+2], blk_bytes[r*4+3]};
      end else begin
        x2  = w[(r - 2) & 15];
        x15 = w[(r - 15) & 15];
        wn = (ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10)) + w[(r - 7) & 15]
           + (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3)) + w[r & 15];
      end
      w[r & 15] = wn;
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(r[5:0]) + wn;
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_hv[i] += v[i];
  endtask

  // Standard padding: 0x80, zeros, then the 64-bit big-endian bit length.
  // A tail that leaves no room for the length spills into a second block.
  task automatic pad_and_close();
    int unsigned pos;
    logic [63:0] bits;
    pos = byte_count[5:0];
    bits = {byte_count, 3'b000};
    blk_bytes[pos] = 8'h80;
    for (int i = pos + 1; i < 64; i++) blk_bytes[i] = 8'h00;
    if (pos >= 56) begin
      compress_blk();
      for (int i = 0; i < 56; i++) blk_bytes[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) blk_bytes[63 - i] = bits[i*8 +: 8];
    compress_blk();
  endtask

  // Absorbs one accepted item and queues the eight digest words it causes.
  task automatic absorb_item(input logic [7:0] d, input logic p, input logic l);
    digest_word_t e;
    if (p) begin
      blk_bytes[byte_count[5:0]] = d;
      byte_count = byte_count + 61'd1;
      if (byte_count[5:0] == 6'd0) compress_blk();
    end
    if (l) begin
      pad_and_close();
      if (dbl_sel) begin
        // The first digest becomes a fresh 32-byte message.
        for (int i = 0; i < 8; i++) begin
          {blk_bytes[i*4], blk_bytes[i*4+1], blk_bytes[i*4+2], blk_bytes[i*4+3]} =
            chain_hv[i];
        end
        reload_iv();
        byte_count = 61'd32;
        pad_and_close();
      end
      for (int i = 0; i < 8; i++) begin
        e.word  = chain_hv[i];
        e.idx   = i[2:0];
        e.lastw = (i == 7);
        digest_q.push_back(e);
      end
      reload_iv();
      byte_count = '0;
    end
  endtask

  // Sender: idle cycles at random, then push held until full is low at an
  // edge. The quiet window keeps push high back to back.
  task automatic send_item(input logic [7:0] d, input logic p, input logic l);
    while (!(items_sent >= 60 && items_sent < 100) && $urandom_range(99) < 23) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    data_byte_i <= d;
    byte_present_i <= p;
    last_byte_i <= l;
    do @(posedge clk_i); while (full);
    absorb_item(d, p, l);
    items_sent++;
  endtask

  // Waits until every queued word has arrived, then lets the engine settle
  // so that a register write never lands on work in flight.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_double(input logic v);
    double_mode_we_i <= 1'b1;
    double_mode_i <= v;
    @(posedge clk_i);
    double_mode_we_i <= 1'b0;
    dbl_sel = v;
  endtask

  // One message of len bytes. Some messages end on a bare last item rather
  // than on a byte, and a few carry ignored items with neither byte nor end.
  task automatic send_message(input int len);
    bit bare_end;
    bare_end = (len == 0) || ($urandom_range(99) < 15);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) send_item($urandom_range(255), 1'b0, 1'b0);
      send_item($urandom_range(255), 1'b1, !bare_end && (i == len - 1));
    end
    if (bare_end) send_item($urandom_range(255), 1'b0, 1'b1);
  endtask

  // Directed table. A row with has_ref carries the known first digest word.
  typedef struct {
    logic [7:0]  d;
    logic        p;
    logic        l;
    bit          has_ref;
    logic [31:0] ref_word;
  } stim_row_t;

  localparam int SplitRow = 11;  // double mode switches on before this row

  stim_row_t stim_tbl[14] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442},  // empty message
    '{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf},  // "abc"
    '{8'ha5, 1'b0, 1'b0, 1'b0, 32'h0},         // neither byte nor end
    '{8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 32'h0},
    '{8'h55, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h3c, 1'b0, 1'b1, 1'b0, 32'h0},         // end without a byte
    '{8'h80, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h7f, 1'b1, 1'b0, 1'b0, 32'h0},         // left open across a mode change
    '{8'h01, 1'b1, 1'b1, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b1, 1'b1, 32'h5df6e0e2},  // empty message, double hashed
    '{8'hfe, 1'b1, 1'b1, 1'b0, 32'h0}
  };

  // Stimulus.
  initial begin
    int len;
    reload_iv();
    byte_count = '0;
    dbl_sel = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    rst_done = 1'b1;
    @(posedge clk_i);
    write_double(1'b0);

    for (int r = 0; r < $size(stim_tbl); r++) begin
      if (r == SplitRow) begin
        drain();
        write_double(1'b1);
      end
      send_item(stim_tbl[r].d, stim_tbl[r].p, stim_tbl[r].l);
      if (stim_tbl[r].has_ref) digest_q[digest_q.size() - 8].word = stim_tbl[r].ref_word;
    end

    // Random messages in four phases of alternating mode. The first phase
    // starts with a message whose padding spills into a second block.
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_double(ph[0]);
      if (ph == 0) send_message(EdgeLen);
      while (items_sent < 75 + 15 * ph) begin
        if ($urandom_range(99) < 10) len = $urandom_range(60, 70);
        else len = $urandom_range(0, 12);
        send_message(len);
      end
    end

    drain();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Receiver: checks the word taken at this edge, then picks pop for the
  // next cycle. A window of results is taken with pop held high.
  initial begin
    digest_word_t e;
    forever begin
      @(posedge clk_i);
      if (rst_done && pop && !empty) begin
        words_seen++;
        if (digest_q.size() == 0) begin
          $display("%0t: digest word %h with none expected", $time, digest_word_o);
          errors++;
        end else begin
          e = digest_q.pop_front();
          if (digest_word_o !== e.word) begin
            $display("%0t: digest_word expected %h actual %h", $time, e.word, digest_word_o);
            errors++;
          end
          if (word_index_o !== e.idx) begin
            $display("%0t: word_index expected %0d actual %0d", $time, e.idx, word_index_o);
            errors++;
          end
          if (last_word_o !== e.lastw) begin
            $display("%0t: last_word expected %b actual %b", $time, e.lastw, last_word_o);
            errors++;
          end
        end
      end
      pop <= (words_seen >= 24 && words_seen < 56) || ($urandom_range(99) >= 23);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
